// ----- sv/rsl_pkg.sv -----
// Shared types, constants and helpers for the ring successor lookup block.
// Used by the top level and its modulo submodule; depends on nothing.
package rsl_pkg;

  localparam int RING_SIZE_DEF = 512;
  localparam int HS_W          = 10;
  localparam int VAL_W         = 16;
  localparam int OUT_W         = 9;
  localparam int WORD_W        = 32;
  localparam int WORD_BW       = 5;

  localparam logic [HS_W-1:0] HS_RESET = 10'd512;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_FMOD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             command;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] owner_node;
    logic [OUT_W-1:0] finger0_start;
    logic [OUT_W-1:0] finger0_node;
    logic [OUT_W-1:0] finger1_start;
    logic [OUT_W-1:0] finger1_node;
    logic [OUT_W-1:0] finger2_start;
    logic [OUT_W-1:0] finger2_node;
    logic             ring_empty;
  } out_item_t;

  // Index of the lowest set bit; zero when the word is empty.
  function automatic logic [WORD_BW-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [WORD_BW-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) idx = WORD_BW'(i);
    end
    return idx;
  endfunction

endpackage

// ----- sv/rsl_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; holds the membership words of the ring successor lookup.
module rsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/rsl_mod.sv -----
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on rsl_pkg for the dividend width.
module rsl_mod #(
  parameter int DIV_W = 10,
  parameter int REM_W = 9
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rsl_pkg::VAL_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]         divisor_i,
  output logic                     done_o,
  output logic [REM_W-1:0]         rem_o
);

  localparam int VW = rsl_pkg::VAL_W;
  localparam int CW = $clog2(VW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [VW-1:0] a_q;
  logic [DIV_W-1:0] m_q;
  logic [DIV_W-1:0] rem_q;

  logic [DIV_W:0]   trial;
  logic             ge;
  logic [DIV_W-1:0] rem_d;

  always_comb begin
    trial = {rem_q, a_q[VW-1]};
    ge    = trial >= {1'b0, m_q};
    rem_d = ge ? DIV_W'(trial - {1'b0, m_q}) : DIV_W'(trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(VW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= dividend_i;
      m_q   <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      a_q   <= {a_q[VW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = REM_W'(rem_q);

endmodule

// ----- sv/ring_successor_lookup_unit.sv -----
// Ring successor lookup: keeps node identifiers of a hash ring as a bit map in
// a word-wide RAM and answers lookups with the owner node and three fingers.
// Depends on rsl_pkg, rsl_mod and rsl_ram.
//
// One item at a time; in_stall_o is high while an item is in work. Every item
// first goes through the shared bit-serial modulo unit. An add then does a
// read-modify-write of one map word. A lookup runs four successor searches
// (owner, then each finger), each preceded by a modulo pass; a search reads one
// 32-bit map word at a time (ST_SRCH_RD, then ST_SRCH_CHK), priority-encodes it,
// and visits at most (RING_SIZE + 31)/32 + 1 words. A lookup can wait in ST_OUT
// for the output register to free up. A lookup on an empty ring ends after its
// modulo pass. The finished result sits in an output register, so the next item
// can start while it waits to be taken.
// Map words carry valid bits in flops, so no clearing pass follows reset.
module ring_successor_lookup_unit #(
  parameter int RING_SIZE = rsl_pkg::RING_SIZE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  rsl_pkg::in_item_t        in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output rsl_pkg::out_item_t       out_item_o,
  input  logic                     cfg_we_i,
  input  logic [rsl_pkg::HS_W-1:0] cfg_wdata_i
);

  localparam int WW = rsl_pkg::WORD_W;
  localparam int BW = rsl_pkg::WORD_BW;
  localparam int VW = rsl_pkg::VAL_W;
  localparam int OW = rsl_pkg::OUT_W;
  localparam int NW = (RING_SIZE + WW - 1) / WW;
  localparam int AW = NW > 1 ? $clog2(NW) : 1;
  localparam int PW = $clog2(RING_SIZE);
  localparam int SW = $clog2(RING_SIZE + 1);

  rsl_pkg::state_e state_q, state_d;

  logic [rsl_pkg::HS_W-1:0] hash_space_q;
  logic                     nonempty_q;
  logic [NW-1:0]            vld_q;
  logic                     out_valid_q;
  logic [1:0]               tgt_q;
  logic                     first_q;

  rsl_pkg::cmd_e      cmd_q;
  logic [SW-1:0]      space_q;
  logic [PW-1:0]      pos_q;
  logic [AW-1:0]      widx_q;
  logic [PW-1:0]      owner_q;
  logic [PW-1:0]      fstart_q [3];
  logic [PW-1:0]      fnode_q  [3];
  rsl_pkg::out_item_t out_q;

  logic [SW-1:0] space_sel;
  logic          mod_start;
  logic [VW-1:0] mod_dividend;
  logic          mod_done;
  logic [PW-1:0] mod_rem;
  logic [AW-1:0] rem_word;

  logic          ram_we;
  logic [WW-1:0] ram_wdata;
  logic [WW-1:0] ram_rdata;
  logic [WW-1:0] cur_word;
  logic [WW-1:0] masked;
  logic [BW-1:0] pos_bit;
  logic [BW-1:0] enc;
  logic          hit;
  logic [PW-1:0] found;
  logic [PW-1:0] owner_src;
  logic          out_load;
  logic [1:0]    tgt_prev;

  // A zero or oversized modulus falls back to the full ring.
  assign space_sel = (hash_space_q == '0 || 32'(hash_space_q) > 32'(RING_SIZE)) ?
                     SW'(RING_SIZE) : SW'(hash_space_q);

  assign rem_word  = AW'(mod_rem >> BW);
  assign pos_bit   = BW'(pos_q);
  assign cur_word  = vld_q[widx_q] ? ram_rdata : '0;
  // The first word of a search only counts bits at or above the start.
  assign masked    = first_q ? (cur_word & ({WW{1'b1}} << pos_bit)) : cur_word;
  assign hit       = |masked;
  assign enc       = rsl_pkg::lowest_set(masked);
  assign found     = PW'({widx_q, enc});
  assign owner_src = (tgt_q == 2'd0) ? found : owner_q;
  assign ram_wdata = cur_word | (WW'(1) << pos_bit);
  assign tgt_prev  = tgt_q - 2'd1;

  always_comb begin
    state_d      = state_q;
    mod_start    = 1'b0;
    mod_dividend = in_item_i.value;
    ram_we       = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      rsl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          mod_start = 1'b1;
          state_d   = rsl_pkg::ST_MOD;
        end
      end
      rsl_pkg::ST_MOD: begin
        if (mod_done) begin
          if (cmd_q == rsl_pkg::CMD_ADD) state_d = rsl_pkg::ST_ADD_RD;
          else if (!nonempty_q)          state_d = rsl_pkg::ST_OUT;
          else                           state_d = rsl_pkg::ST_SRCH_RD;
        end
      end
      rsl_pkg::ST_ADD_RD: state_d = rsl_pkg::ST_ADD_WR;
      rsl_pkg::ST_ADD_WR: begin
        ram_we  = 1'b1;
        state_d = rsl_pkg::ST_IDLE;
      end
      rsl_pkg::ST_SRCH_RD: state_d = rsl_pkg::ST_SRCH_CHK;
      rsl_pkg::ST_SRCH_CHK: begin
        if (!hit) begin
          state_d = rsl_pkg::ST_SRCH_RD;
        end else if (tgt_q == 2'd3) begin
          state_d = rsl_pkg::ST_OUT;
        end else begin
          // next finger start: owner plus 1, 2 or 4
          mod_start    = 1'b1;
          mod_dividend = VW'(owner_src) + (VW'(1) << tgt_q);
          state_d      = rsl_pkg::ST_FMOD;
        end
      end
      rsl_pkg::ST_FMOD: begin
        if (mod_done) state_d = rsl_pkg::ST_SRCH_RD;
      end
      rsl_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = rsl_pkg::ST_IDLE;
        end
      end
      default: state_d = rsl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rsl_pkg::ST_IDLE;
      hash_space_q <= rsl_pkg::HS_RESET;
      nonempty_q   <= 1'b0;
      vld_q        <= '0;
      out_valid_q  <= 1'b0;
      tgt_q        <= '0;
      first_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) hash_space_q <= cfg_wdata_i;
      if (ram_we) begin
        vld_q[widx_q] <= 1'b1;
        nonempty_q    <= 1'b1;
      end
      if (out_load)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (state_q == rsl_pkg::ST_IDLE) tgt_q <= '0;
      else if (mod_start)              tgt_q <= tgt_q + 2'd1;
      if (mod_done)                    first_q <= 1'b1;
      else if (state_q == rsl_pkg::ST_SRCH_CHK) first_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rsl_pkg::ST_IDLE && in_valid_i) begin
      cmd_q   <= rsl_pkg::cmd_e'(in_item_i.command);
      space_q <= space_sel;
    end
    if (mod_done) begin
      pos_q  <= mod_rem;
      widx_q <= rem_word;
      if (state_q == rsl_pkg::ST_FMOD) fstart_q[tgt_prev] <= mod_rem;
    end
    if (state_q == rsl_pkg::ST_SRCH_CHK) begin
      if (!hit) begin
        // advance to the next word, wrap to the bottom of the map
        widx_q <= (widx_q == AW'(NW - 1)) ? '0 : widx_q + 1'b1;
      end else if (tgt_q == 2'd0) begin
        owner_q <= found;
      end else begin
        fnode_q[tgt_prev] <= found;
      end
    end
    if (out_load) begin
      if (!nonempty_q) begin
        out_q.owner_node    <= '0;
        out_q.finger0_start <= '0;
        out_q.finger0_node  <= '0;
        out_q.finger1_start <= '0;
        out_q.finger1_node  <= '0;
        out_q.finger2_start <= '0;
        out_q.finger2_node  <= '0;
        out_q.ring_empty    <= 1'b1;
      end else begin
        out_q.owner_node    <= OW'(owner_q);
        out_q.finger0_start <= OW'(fstart_q[0]);
        out_q.finger0_node  <= OW'(fnode_q[0]);
        out_q.finger1_start <= OW'(fstart_q[1]);
        out_q.finger1_node  <= OW'(fnode_q[1]);
        out_q.finger2_start <= OW'(fstart_q[2]);
        out_q.finger2_node  <= OW'(fnode_q[2]);
        out_q.ring_empty    <= 1'b0;
      end
    end
  end

  rsl_mod #(
    .DIV_W (SW),
    .REM_W (PW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (state_q == rsl_pkg::ST_IDLE ? space_sel : space_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  rsl_ram #(
    .WIDTH (WW),
    .DEPTH (NW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_q),
    .wdata_i (ram_wdata),
    .raddr_i (widx_q),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = state_q != rsl_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_mod_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == rsl_pkg::ST_MOD || state_q == rsl_pkg::ST_FMOD))
    else $error("modulo result arrived outside a wait state");

  a_write_marks_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (vld_q[$past(widx_q)] && nonempty_q))
    else $error("map write did not mark its word valid");

  a_search_needs_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsl_pkg::ST_SRCH_RD) |-> nonempty_q)
    else $error("successor search started on an empty ring");

  a_empty_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.ring_empty) |->
      (out_q.owner_node == '0 && out_q.finger0_node == '0 &&
       out_q.finger2_start == '0 && out_q.finger2_node == '0))
    else $error("empty ring result carries nonzero fields");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for ring_successor_lookup_unit: directed table, then random phases of
// adds and lookups over several ring sizes, checked against a ring map predictor.
// Depends on rsl_pkg and the RTL of the block.
module tb_top;

  localparam int RING_SZ      = rsl_pkg::RING_SIZE_DEF;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 9;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TYPED,
    ROW_MODULUS
  } row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    rsl_pkg::in_item_t        item;
    rsl_pkg::out_item_t       want;
    logic [rsl_pkg::HS_W-1:0] modulus;
  } stim_row_t;

  localparam rsl_pkg::out_item_t NO_RES    = '0;
  localparam rsl_pkg::out_item_t EMPTY_RES =
    '{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 1'b1};
  // Node 0 alone on a 512 ring: every finger wraps back to it.
  localparam rsl_pkg::out_item_t LONE_ZERO =
    '{9'd0, 9'd1, 9'd0, 9'd2, 9'd0, 9'd4, 9'd0, 1'b0};

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  rsl_pkg::in_item_t        in_item   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  rsl_pkg::out_item_t       out_item;
  logic                     cfg_we    = 1'b0;
  logic [rsl_pkg::HS_W-1:0] cfg_wdata = '0;

  logic               drv_typed = 1'b0;
  rsl_pkg::out_item_t drv_want  = '0;
  bit                 src_idles = 1'b1;
  bit                 sink_idles = 1'b1;
  bit                 hold_sink = 1'b0;
  int unsigned        mismatches = 0;

  // Predictor state
  logic [RING_SZ-1:0]       ring_map     = '0;
  int unsigned              ring_nodes   = 0;
  logic [rsl_pkg::HS_W-1:0] ring_modulus = rsl_pkg::HS_RESET;
  rsl_pkg::out_item_t       pending_lookups [$];

  wire in_beat  = in_valid && !in_stall;
  wire out_beat = out_valid && !out_stall;

  always #1 clk = ~clk;

  ring_successor_lookup_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  function automatic int unsigned live_space();
    if (ring_modulus == 0 || ring_modulus > RING_SZ) return RING_SZ;
    return ring_modulus;
  endfunction

  // First member at or after pos, else the smallest member.
  function automatic int unsigned next_member(int unsigned pos);
    for (int unsigned i = pos; i < RING_SZ; i++) if (ring_map[i]) return i;
    for (int unsigned i = 0; i < RING_SZ; i++) if (ring_map[i]) return i;
    return 0;
  endfunction

  // Apply one beat to the ring; returns 1 when it yields a lookup result.
  function automatic bit predict_beat(input rsl_pkg::in_item_t item,
                                      output rsl_pkg::out_item_t res);
    int unsigned space;
    int unsigned pos;
    int unsigned owner;
    int unsigned start;
    space = live_space();
    pos   = item.value % space;
    res   = '0;
    if (item.command == rsl_pkg::CMD_ADD) begin
      if (!ring_map[pos]) begin
        ring_map[pos] = 1'b1;
        ring_nodes++;
      end
      return 1'b0;
    end
    if (ring_nodes == 0) begin
      res.ring_empty = 1'b1;
      return 1'b1;
    end
    owner = next_member(pos);
    res.owner_node = rsl_pkg::OUT_W'(owner);
    start = (owner + 1) % space;
    res.finger0_start = rsl_pkg::OUT_W'(start);
    res.finger0_node  = rsl_pkg::OUT_W'(next_member(start));
    start = (owner + 2) % space;
    res.finger1_start = rsl_pkg::OUT_W'(start);
    res.finger1_node  = rsl_pkg::OUT_W'(next_member(start));
    start = (owner + 4) % space;
    res.finger2_start = rsl_pkg::OUT_W'(start);
    res.finger2_node  = rsl_pkg::OUT_W'(next_member(start));
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
  endtask

  always @(posedge clk) begin : scoreboard
    rsl_pkg::out_item_t want;
    rsl_pkg::out_item_t calc;
    if (rst_n) begin
      // Drain before fill: a result never belongs to the beat taken at the same edge.
      if (out_beat) begin
        if (pending_lookups.size() == 0) begin
          report_mismatch("result with nothing owed, owner_node", out_item.owner_node, 0);
        end else begin
          want = pending_lookups.pop_front();
          if (out_item.owner_node != want.owner_node)
            report_mismatch("owner_node", out_item.owner_node, want.owner_node);
          if (out_item.finger0_start != want.finger0_start)
            report_mismatch("finger0_start", out_item.finger0_start, want.finger0_start);
          if (out_item.finger0_node != want.finger0_node)
            report_mismatch("finger0_node", out_item.finger0_node, want.finger0_node);
          if (out_item.finger1_start != want.finger1_start)
            report_mismatch("finger1_start", out_item.finger1_start, want.finger1_start);
          if (out_item.finger1_node != want.finger1_node)
            report_mismatch("finger1_node", out_item.finger1_node, want.finger1_node);
          if (out_item.finger2_start != want.finger2_start)
            report_mismatch("finger2_start", out_item.finger2_start, want.finger2_start);
          if (out_item.finger2_node != want.finger2_node)
            report_mismatch("finger2_node", out_item.finger2_node, want.finger2_node);
          if (out_item.ring_empty != want.ring_empty)
            report_mismatch("ring_empty", out_item.ring_empty, want.ring_empty);
        end
      end
      if (in_beat) begin
        if (predict_beat(in_item, calc))
          pending_lookups.push_back(drv_typed ? drv_want : calc);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (in_beat || out_beat) quiet = 0;
      else quiet++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    @(posedge rst_n);
    forever begin
      if (hold_sink) begin
        hold_sink = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = sink_idles ? $urandom_range(0, 7) : 0;
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_beat);
      @(negedge clk);
    end
  end

  task automatic send_beat(rsl_pkg::in_item_t item, bit typed, rsl_pkg::out_item_t want);
    int unsigned gap;
    gap = src_idles ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item   <= item;
    drv_typed <= typed;
    drv_want  <= want;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_beat);
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed lookup, then let a trailing add finish.
  task automatic settle_ring();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_modulus(logic [rsl_pkg::HS_W-1:0] modulus);
    cfg_we    <= 1'b1;
    cfg_wdata <= modulus;
    @(negedge clk);
    cfg_we       <= 1'b0;
    ring_modulus = modulus;
  endtask

  initial begin : stimulus
    stim_row_t                rows [24];
    logic [rsl_pkg::HS_W-1:0] moduli [NUM_PHASES];
    int unsigned              add_pct [NUM_PHASES];
    rsl_pkg::in_item_t        item;

    rows = '{
      '{ROW_TYPED,   '{rsl_pkg::CMD_LOOKUP, 16'd0},     EMPTY_RES, 10'd0},
      '{ROW_TYPED,   '{rsl_pkg::CMD_LOOKUP, 16'd65535}, EMPTY_RES, 10'd0},
      '{ROW_PREDICT, '{rsl_pkg::CMD_ADD,    16'd0},     NO_RES,    10'd0},
      '{ROW_TYPED,   '{rsl_pkg::CMD_LOOKUP, 16'd65535}, LONE_ZERO, 10'd0},
      '{ROW_PREDICT, '{rsl_pkg::CMD_ADD,    16'd512},   NO_RES,    10'd0},
      '{ROW_PREDICT, '{rsl_pkg::CMD_ADD,    16'd65535}, NO_RES,    10'd0},
      '{ROW_PREDICT, '{rsl_pkg::CMD_LOOKUP, 16'd511},   NO_RES,    10'd0},
      '{ROW_PREDICT, '{rsl_pkg::CMD_LOOKUP, 16'd1},     NO_RES,    10'd0},
      '{ROW_PREDICT, '{rsl_pkg::CMD_ADD,    16'd37},    NO_RES,    10'd0},
      '{ROW_PREDICT, '{rsl_pkg::CMD_LOOKUP, 16'd300},   NO_RES,    10'd0},
      '{ROW_MODULUS, '0,                                NO_RES,    10'd0},
      '{ROW_PREDICT, '{rsl_pkg::CMD_LOOKUP, 16'd40000}, NO_RES,    10'd0},
      '{ROW_MODULUS, '0,                                NO_RES,    10'd1023},
      '{ROW_PREDICT, '{rsl_pkg::CMD_LOOKUP, 16'd38},    NO_RES,    10'd0},
      '{ROW_MODULUS, '0,                                NO_RES,    10'd1},
      '{ROW_PREDICT, '{rsl_pkg::CMD_ADD,    16'd12345}, NO_RES,    10'd0},
      '{ROW_PREDICT, '{rsl_pkg::CMD_LOOKUP, 16'd65535}, NO_RES,    10'd0},
      // Shrunken ring: members above the modulus still come back as owners.
      '{ROW_MODULUS, '0,                                NO_RES,    10'd7},
      '{ROW_PREDICT, '{rsl_pkg::CMD_LOOKUP, 16'd6},     NO_RES,    10'd0},
      '{ROW_PREDICT, '{rsl_pkg::CMD_ADD,    16'd13},    NO_RES,    10'd0},
      '{ROW_PREDICT, '{rsl_pkg::CMD_LOOKUP, 16'd6},     NO_RES,    10'd0},
      '{ROW_MODULUS, '0,                                NO_RES,    10'd513},
      '{ROW_PREDICT, '{rsl_pkg::CMD_LOOKUP, 16'd510},   NO_RES,    10'd0},
      '{ROW_MODULUS, '0,                                NO_RES,    10'd512}
    };
    moduli  = '{10'd512, 10'd2, 10'd300, 10'd1023, 10'd64, 10'd0, 10'd1, 10'd513, 10'd512};
    add_pct = '{8, 60, 20, 15, 40, 10, 50, 30, 25};

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_MODULUS) begin
        settle_ring();
        write_modulus(rows[r].modulus);
      end else begin
        send_beat(rows[r].item, rows[r].kind == ROW_TYPED, rows[r].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_ring();
      write_modulus(p == NUM_PHASES - 1 ? rsl_pkg::HS_W'($urandom_range(1, 1023))
                                        : moduli[p]);
      src_idles  = (p % 3 != 1);
      sink_idles = (p % 4 != 2);
      // Long sink hold-off while lookups keep coming, so the input backs up.
      if (p == 3) hold_sink = 1'b1;
      repeat (PHASE_ITEMS) begin
        item.command = ($urandom_range(0, 99) < add_pct[p]) ? rsl_pkg::CMD_ADD
                                                            : rsl_pkg::CMD_LOOKUP;
        item.value   = ($urandom_range(0, 3) == 0)
                       ? rsl_pkg::VAL_W'($urandom_range(0, 1023))
                       : rsl_pkg::VAL_W'($urandom_range(0, 65535));
        send_beat(item, 1'b0, NO_RES);
      end
    end
    settle_ring();

    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rsl_pkg.sv
sv/rsl_ram.sv
sv/rsl_mod.sv
sv/ring_successor_lookup_unit.sv
bench/tb_top.sv
